/* rtl/core/iso9660_dir_record_parser_unit_macros.svh */
// ----------------------------------------------------------------------------
// Directory record parser assertion macros
// Concurrent check helpers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ISO9660_DIR_RECORD_PARSER_UNIT_MACROS_SVH
`define ISO9660_DIR_RECORD_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH
`define DIRP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dirp check failed");
`define DIRP_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("dirp forbidden condition");
`else
`define DIRP_ASSERT(label, clk, rst, prop)
`define DIRP_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

/* rtl/core/dirp_pkg.sv */
// ----------------------------------------------------------------------------
// Directory record parser package
// Shared types, codes and constants of the parser unit.
// ----------------------------------------------------------------------------
package dirp_pkg;

   localparam int SECTOR_BYTES_DEF = 2048;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [7:0] MIN_RECORD    = 8'd34;
   localparam logic [8:0] IDENT_START   = 9'd33;
   localparam logic [7:0] IDENT_POS     = 8'd33;
   localparam logic [7:0] IDENT_LEN_POS = 8'd32;
   localparam logic [7:0] FLAGS_POS     = 8'd25;
   localparam int         DIR_BIT       = 1;

   typedef enum logic [1:0] {
      KIND_RECORD = 2'd0,
      KIND_END    = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_SHORT   = 2'd1,
      ERR_NAME    = 2'd2,
      ERR_OVERRUN = 2'd3
   } err_type;

   // work handed from the byte parser to the result sequencer
   typedef struct packed {
      logic        rec_valid;
      logic [31:0] extent_lba;
      logic [31:0] data_length;
      logic        dir_entry;
      logic [7:0]  id_len;
      logic        tail_valid;
      kind_type    tail_kind;
      err_type     tail_err;
   } job_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] extent_lba;
      logic [31:0] data_length;
      logic        dir_entry;
      logic [7:0]  id_len;
      err_type     fault_code;
      logic        last;
   } rsp_type;

endpackage

/* rtl/core/dirp_if.sv */
// ----------------------------------------------------------------------------
// Directory record parser channels
// Valid/ready channels for input bytes and parse results.
// ----------------------------------------------------------------------------
interface dirp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dirp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] extent_lba;
   logic [31:0] data_length;
   logic        dir_entry;
   logic [7:0]  id_len;
   logic [1:0]  fault_code;
   logic        last;

   modport source (output valid, output kind, output extent_lba, output data_length,
                   output dir_entry, output id_len, output fault_code,
                   output last, input ready);
   modport sink (input valid, input kind, input extent_lba, input data_length,
                 input dir_entry, input id_len, input fault_code,
                 input last, output ready);
endinterface

/* rtl/core/dirp_front.sv */
// ----------------------------------------------------------------------------
// Directory record parser front end
// Takes one byte per cycle while the job queue is not full, tracks sector/record position and emits jobs.
// ----------------------------------------------------------------------------
module dirp_front #(
   parameter int SECTOR_BYTES = dirp_pkg::SECTOR_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   dirp_req_if.sink          req,
   input  logic              q_full,
   output logic              push,
   output dirp_pkg::job_type job
);
   import dirp_pkg::*;

   localparam int SPW = $clog2(SECTOR_BYTES);
   localparam logic [SPW-1:0] LAST_POS = SPW'(SECTOR_BYTES - 1);

   logic [SPW-1:0] sector_pos_ff, sector_pos_in;
   logic [7:0]     rec_pos_ff, rec_pos_in;
   logic [7:0]     rec_len_ff, rec_len_in;
   logic [7:0]     ident_len_ff, ident_len_in;
   logic [31:0]    extent_ff, extent_in;
   logic [31:0]    length_ff, length_in;
   logic           dir_ff, dir_in;
   logic [7:0]     first_ff, first_in;
   logic           skip_ff, skip_in;
   logic           failed_ff, failed_in;

   logic           take;
   logic [SPW-1:0] pos_next;
   logic [7:0]     idx_next;
   logic [1:0]     ext_lane;
   logic [1:0]     len_lane;
   err_type        err;

   assign req.ready = !q_full;
   assign take      = req.valid && req.ready;
   assign pos_next  = (sector_pos_ff == LAST_POS) ? '0 : sector_pos_ff + 1'b1;
   assign idx_next  = rec_pos_ff + 8'd1;
   assign ext_lane  = 2'(rec_pos_ff - 8'd2);
   assign len_lane  = 2'(rec_pos_ff - 8'd10);

   always_comb begin
      sector_pos_in = sector_pos_ff;
      rec_pos_in    = rec_pos_ff;
      rec_len_in    = rec_len_ff;
      ident_len_in  = ident_len_ff;
      extent_in     = extent_ff;
      length_in     = length_ff;
      dir_in        = dir_ff;
      first_in      = first_ff;
      skip_in       = skip_ff;
      failed_in     = failed_ff;
      err           = ERR_NONE;
      job           = '0;
      push          = 1'b0;

      if (take && !failed_ff) begin
         if (skip_ff) begin
            if (pos_next == '0) begin
               skip_in = 1'b0;
            end
         end else if (rec_pos_ff == 8'd0) begin
            if (req.data_byte == 8'd0) begin
               // zero length: rest of sector is padding, unless this was its last byte
               if (pos_next != '0) begin
                  skip_in = 1'b1;
               end
            end else if (req.data_byte < MIN_RECORD) begin
               err = ERR_SHORT;
            end else begin
               rec_len_in   = req.data_byte;
               rec_pos_in   = 8'd1;
               ident_len_in = '0;
               extent_in    = '0;
               length_in    = '0;
               dir_in       = 1'b0;
               first_in     = '0;
            end
         end else begin
            if (rec_pos_ff inside {[8'd2:8'd5]}) begin
               extent_in[{ext_lane, 3'b000} +: 8] = req.data_byte;
            end else if (rec_pos_ff inside {[8'd10:8'd13]}) begin
               length_in[{len_lane, 3'b000} +: 8] = req.data_byte;
            end else if (rec_pos_ff == FLAGS_POS) begin
               dir_in = req.data_byte[DIR_BIT];
            end else if (rec_pos_ff == IDENT_LEN_POS) begin
               ident_len_in = req.data_byte;
               if ((IDENT_START + {1'b0, req.data_byte}) > {1'b0, rec_len_ff}) begin
                  err = ERR_NAME;
               end
            end else if (rec_pos_ff == IDENT_POS) begin
               first_in = req.data_byte;
            end

            if (err == ERR_NONE) begin
               rec_pos_in = idx_next;
               if (idx_next >= rec_len_ff) begin
                  rec_pos_in = 8'd0;
                  // self and parent entries are not reported
                  if (!(ident_len_in == 8'd1 && first_in[7:1] == 7'd0)) begin
                     job.rec_valid = 1'b1;
                  end
               end
            end
         end
         sector_pos_in = pos_next;

         job.extent_lba  = extent_in;
         job.data_length = length_in;
         job.dir_entry   = dir_in;
         job.id_len      = ident_len_in;

         if (err != ERR_NONE) begin
            job.tail_valid = 1'b1;
            job.tail_kind  = KIND_ERROR;
            job.tail_err   = err;
            failed_in      = 1'b1;
         end else if (req.last_byte) begin
            job.tail_valid = 1'b1;
            if (rec_pos_in != 8'd0) begin
               job.tail_kind = KIND_ERROR;
               job.tail_err  = ERR_OVERRUN;
            end else begin
               job.tail_kind = KIND_END;
            end
         end
         push = job.rec_valid || job.tail_valid;
      end

      // end of extent: all parse state back to its reset value
      if (take && req.last_byte) begin
         sector_pos_in = '0;
         rec_pos_in    = '0;
         rec_len_in    = '0;
         ident_len_in  = '0;
         extent_in     = '0;
         length_in     = '0;
         dir_in        = 1'b0;
         first_in      = '0;
         skip_in       = 1'b0;
         failed_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_pos_ff <= '0;
         rec_pos_ff    <= '0;
         rec_len_ff    <= '0;
         ident_len_ff  <= '0;
         extent_ff     <= '0;
         length_ff     <= '0;
         dir_ff        <= 1'b0;
         first_ff      <= '0;
         skip_ff       <= 1'b0;
         failed_ff     <= 1'b0;
      end else begin
         sector_pos_ff <= sector_pos_in;
         rec_pos_ff    <= rec_pos_in;
         rec_len_ff    <= rec_len_in;
         ident_len_ff  <= ident_len_in;
         extent_ff     <= extent_in;
         length_ff     <= length_in;
         dir_ff        <= dir_in;
         first_ff      <= first_in;
         skip_ff       <= skip_in;
         failed_ff     <= failed_in;
      end
   end

endmodule

/* rtl/core/dirp_queue.sv */
// ----------------------------------------------------------------------------
// Directory record parser job queue
// Short FIFO between the byte parser and the result sequencer.
// ----------------------------------------------------------------------------
`include "iso9660_dir_record_parser_unit_macros.svh"

module dirp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dirp_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output dirp_pkg::job_type head_job
);
   import dirp_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

   job_type       entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `DIRP_ASSERT_NEVER(a_push_full, clock, reset, push && full)
   `DIRP_ASSERT_NEVER(a_pop_empty, clock, reset, pop && empty)
   `DIRP_ASSERT(a_count_ptrs, clock, reset, (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))

endmodule

/* rtl/core/dirp_back.sv */
// ----------------------------------------------------------------------------
// Directory record parser back end
// Expands queued jobs into one or two results through an output register.
// ----------------------------------------------------------------------------
module dirp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  dirp_pkg::job_type head_job,
   output logic              pop,
   dirp_rsp_if.source        rsp
);
   import dirp_pkg::*;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    phase_ff, phase_in;   // record part of head job already sent
   logic    load;

   assign load = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      phase_in     = phase_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b0;
         if (!q_empty) begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            if (!phase_ff && head_job.rec_valid) begin
               rsp_in.kind        = KIND_RECORD;
               rsp_in.extent_lba  = head_job.extent_lba;
               rsp_in.data_length = head_job.data_length;
               rsp_in.dir_entry   = head_job.dir_entry;
               rsp_in.id_len      = head_job.id_len;
               rsp_in.fault_code  = ERR_NONE;
               rsp_in.last        = !head_job.tail_valid;
               if (head_job.tail_valid) begin
                  phase_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               rsp_in.kind       = head_job.tail_kind;
               rsp_in.fault_code = head_job.tail_err;
               rsp_in.last       = 1'b1;
               phase_in          = 1'b0;
               pop               = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = rsp_ff.kind;
   assign rsp.extent_lba  = rsp_ff.extent_lba;
   assign rsp.data_length = rsp_ff.data_length;
   assign rsp.dir_entry   = rsp_ff.dir_entry;
   assign rsp.id_len      = rsp_ff.id_len;
   assign rsp.fault_code  = rsp_ff.fault_code;
   assign rsp.last        = rsp_ff.last;

endmodule

/* rtl/core/iso9660_dir_record_parser_unit.sv */
// ----------------------------------------------------------------------------
// ISO9660 directory record parser unit
// Parses a byte stream of one directory extent into entry and status results.
// ----------------------------------------------------------------------------
// The unit accepts one extent byte per clock cycle and keeps accepting while
// results wait downstream. The front end parses each byte; any results it
// causes (at most two: a record and an end or error status) go as one job
// into a four-entry queue. The back end turns each job into results through
// an output register, one result per cycle unless stalled, so a result goes
// through the queue and the output register after its byte. Input throughput
// is one byte per cycle, limited only by the output side taking one result
// per cycle when the queue fills. No clearing pass follows reset.
module iso9660_dir_record_parser_unit #(
   parameter int SECTOR_BYTES = dirp_pkg::SECTOR_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dirp_req_if.sink   req_ch,
   dirp_rsp_if.source rsp_ch
);
   import dirp_pkg::*;

   logic    push;
   logic    pop;
   logic    q_full;
   logic    q_empty;
   job_type push_job;
   job_type head_job;

   dirp_front #(
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .q_full (q_full),
      .push   (push),
      .job    (push_job)
   );

   dirp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_job (head_job)
   );

   dirp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .head_job (head_job),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

endmodule

/* tb/iso9660_dir_record_parser_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ISO9660 directory record parser unit testbench
// Streams directory extents into the parser one byte per item and checks each
// result against an in-bench tracker of sector, record and field state.
// Extents mix clean records, self and parent entries, padding, sector
// crossings, broken records and noise, with random gaps on both channels.
// ----------------------------------------------------------------------------
module iso9660_dir_record_parser_unit_tb;
   import dirp_pkg::*;

   localparam int          SECTOR         = 512;
   localparam int unsigned RANDOM_BYTES   = 1100;
   localparam int unsigned RESULTS_WANTED = 48;
   localparam int unsigned LONG_EXTENTS   = 1;
   localparam int          IDLE_LIMIT     = 1000;
   localparam int          MAX_PRINTS     = 100;

   typedef enum int {
      LONG_PAD_TO_EDGE,
      LONG_ZERO_AT_EDGE,
      LONG_CROSS_EDGE
   } long_shape_type;

   typedef enum int {
      BROKEN_SHORT,
      BROKEN_NAME,
      BROKEN_OVERRUN,
      BROKEN_NOISE
   } broken_type;

   // Tracks parser state per accepted byte and holds the results still owed.
   class dir_entry_book #(int SECTOR_LEN = 2048);
      int unsigned sector_pos;
      int unsigned rec_pos;
      int unsigned rec_len;
      int unsigned name_len;
      logic [7:0]  first_name;
      logic [31:0] lba_acc;
      logic [31:0] len_acc;
      logic        dir_bit;
      logic        in_padding;
      logic        aborted;
      rsp_type     entries_due[$];
      int unsigned results_due;
      int unsigned mismatches;

      function new();
         clear_state();
         results_due = 0;
         mismatches  = 0;
      endfunction

      function void clear_state();
         sector_pos = 0;
         rec_pos    = 0;
         rec_len    = 0;
         name_len   = 0;
         first_name = '0;
         lba_acc    = '0;
         len_acc    = '0;
         dir_bit    = 1'b0;
         in_padding = 1'b0;
         aborted    = 1'b0;
      endfunction

      function void take_byte(logic [7:0] b, logic fin);
         rsp_type     batch[$];
         rsp_type     r;
         err_type     err;
         int unsigned nxt;
         err = ERR_NONE;
         // after an error everything up to and including the final byte is dropped
         if (aborted) begin
            if (fin) clear_state();
            return;
         end
         nxt = sector_pos + 1;
         if (nxt >= SECTOR_LEN) nxt = 0;
         if (in_padding) begin
            if (nxt == 0) in_padding = 1'b0;
         end else if (rec_pos == 0) begin
            if (b == 8'd0) begin
               // a zero on the last byte of a sector has no padding behind it
               if (nxt != 0) in_padding = 1'b1;
            end else if (b < MIN_RECORD) begin
               err = ERR_SHORT;
            end else begin
               rec_len    = b;
               rec_pos    = 1;
               name_len   = 0;
               lba_acc    = '0;
               len_acc    = '0;
               dir_bit    = 1'b0;
               first_name = '0;
            end
         end else begin
            // little-endian extent at bytes 2..5, data length at 10..13
            if (rec_pos >= 2 && rec_pos <= 5)
               lba_acc |= 32'(b) << (8 * (rec_pos - 2));
            else if (rec_pos >= 10 && rec_pos <= 13)
               len_acc |= 32'(b) << (8 * (rec_pos - 10));
            else if (rec_pos == FLAGS_POS)
               dir_bit = b[DIR_BIT];
            else if (rec_pos == IDENT_LEN_POS) begin
               name_len = b;
               if (int'(IDENT_POS) + int'(b) > int'(rec_len)) err = ERR_NAME;
            end else if (rec_pos == IDENT_POS)
               first_name = b;
            if (err == ERR_NONE) begin
               rec_pos++;
               if (rec_pos >= rec_len) begin
                  rec_pos = 0;
                  // self and parent entries give no result
                  if (!(name_len == 1 && first_name <= 8'd1)) begin
                     r             = '0;
                     r.kind        = KIND_RECORD;
                     r.extent_lba  = lba_acc;
                     r.data_length = len_acc;
                     r.dir_entry   = dir_bit;
                     r.id_len      = 8'(name_len);
                     r.fault_code  = ERR_NONE;
                     batch = {batch, r};
                  end
               end
            end
         end
         sector_pos = nxt;
         if (err != ERR_NONE) begin
            r            = '0;
            r.kind       = KIND_ERROR;
            r.fault_code = err;
            batch = {batch, r};
            aborted = 1'b1;
         end else if (fin) begin
            r = '0;
            if (rec_pos != 0) begin
               r.kind       = KIND_ERROR;
               r.fault_code = ERR_OVERRUN;
            end else begin
               r.kind       = KIND_END;
               r.fault_code = ERR_NONE;
            end
            batch = {batch, r};
         end
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) begin
            entries_due = {entries_due, batch[i]};
            results_due++;
         end
         if (fin) clear_state();
      endfunction

      task flag_mismatch(string what);
         if (mismatches < MAX_PRINTS) $display("%0t mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task match_entry(rsp_type got);
         rsp_type want;
         if (entries_due.size() == 0) begin
            flag_mismatch($sformatf("result kind %0d with nothing owed", got.kind));
            return;
         end
         want = entries_due.pop_front();
         if (got.kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
         if (got.extent_lba !== want.extent_lba)
            flag_mismatch($sformatf("extent_lba %h, want %h", got.extent_lba,
                                    want.extent_lba));
         if (got.data_length !== want.data_length)
            flag_mismatch($sformatf("data_length %h, want %h", got.data_length,
                                    want.data_length));
         if (got.dir_entry !== want.dir_entry)
            flag_mismatch($sformatf("dir_entry %b, want %b", got.dir_entry,
                                    want.dir_entry));
         if (got.id_len !== want.id_len)
            flag_mismatch($sformatf("id_len %0d, want %0d", got.id_len,
                                    want.id_len));
         if (got.fault_code !== want.fault_code)
            flag_mismatch($sformatf("fault_code %0d, want %0d", got.fault_code,
                                    want.fault_code));
         if (got.last !== want.last)
            flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   dirp_req_if req_ch ();
   dirp_rsp_if rsp_ch ();

   iso9660_dir_record_parser_unit #(
      .SECTOR_BYTES(SECTOR)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dir_entry_book #(SECTOR) book = new;

   logic [7:0]  extent_bytes[$];
   int unsigned bytes_sent = 0;
   logic        send_calm  = 1'b0;
   logic        recv_calm  = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- extents

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 3))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return 32'($urandom);
      endcase
   endfunction

   function automatic int unsigned pick_len();
      case ($urandom_range(0, 19))
         0:       return $urandom_range(200, 255);
         1:       return MIN_RECORD;
         default: return $urandom_range(MIN_RECORD, 48);
      endcase
   endfunction

   function automatic void add_noise(int unsigned count);
      repeat (count) extent_bytes = {extent_bytes, 8'($urandom)};
   endfunction

   function automatic void add_record(int unsigned len, int unsigned nlen,
                                      logic [7:0] first);
      logic [31:0] lba;
      logic [31:0] dlen;
      logic [7:0]  b;
      lba  = pick_word();
      dlen = pick_word();
      for (int unsigned i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (i == 0)
            b = 8'(len);
         else if (i >= 2 && i <= 5)
            b = lba[8 * (i - 2) +: 8];
         else if (i >= 10 && i <= 13)
            b = dlen[8 * (i - 10) +: 8];
         else if (i == IDENT_LEN_POS)
            b = 8'(nlen);
         else if (i == IDENT_POS)
            b = first;
         extent_bytes = {extent_bytes, b};
      end
   endfunction

   // well-formed record with a name that fits
   function automatic void add_any(int unsigned len);
      int unsigned room;
      room = len - int'(IDENT_POS);
      case ($urandom_range(0, 3))
         0:       add_record(len, 1, 8'($urandom_range(0, 1)));
         1:       add_record(len, 1, 8'($urandom));
         2:       add_record(len, room, 8'($urandom));
         default: add_record(len, $urandom_range(0, room), 8'($urandom));
      endcase
   endfunction

   function automatic void build_clean();
      repeat ($urandom_range(1, 4)) add_any(pick_len());
      if ($urandom_range(0, 2) == 0) begin
         extent_bytes = {extent_bytes, 8'h00};
         add_noise($urandom_range(0, 8));
      end
   endfunction

   function automatic void build_broken(broken_type how);
      int unsigned len;
      int unsigned keep;
      if (how != BROKEN_NOISE) repeat ($urandom_range(0, 2)) add_any(pick_len());
      case (how)
         BROKEN_SHORT: begin
            extent_bytes = {extent_bytes, 8'($urandom_range(1, MIN_RECORD - 1))};
            add_noise($urandom_range(0, 4));
         end
         BROKEN_NAME: begin
            len = $urandom_range(MIN_RECORD, 48);
            add_record(len, $urandom_range(len - int'(IDENT_LEN_POS), 255), 8'($urandom));
            // half the time the final byte is the name length byte itself
            if ($urandom_range(0, 1) == 0)
               repeat (len - int'(IDENT_POS)) extent_bytes.delete(extent_bytes.size() - 1);
            else
               add_noise($urandom_range(0, 6));
         end
         BROKEN_OVERRUN: begin
            len = pick_len();
            add_record(len, $urandom_range(0, len - int'(IDENT_POS)), 8'($urandom));
            keep = $urandom_range(1, len - 1);
            repeat (len - keep) extent_bytes.delete(extent_bytes.size() - 1);
         end
         default: add_noise($urandom_range(1, 40));
      endcase
   endfunction

   // extents that reach the first sector boundary
   function automatic void build_long(long_shape_type shape);
      int unsigned room;
      case (shape)
         LONG_PAD_TO_EDGE: begin
            while (extent_bytes.size() + 90 < SECTOR) add_any($urandom_range(MIN_RECORD, 48));
            extent_bytes = {extent_bytes, 8'h00};
            while (extent_bytes.size() < SECTOR) extent_bytes = {extent_bytes, 8'($urandom)};
         end
         LONG_ZERO_AT_EDGE: begin
            while (SECTOR - extent_bytes.size() > 100) add_any($urandom_range(MIN_RECORD, 48));
            add_any(SECTOR - extent_bytes.size() - 1);
            extent_bytes = {extent_bytes, 8'h00};
         end
         default: begin
            while (SECTOR - extent_bytes.size() > 60) add_any($urandom_range(MIN_RECORD, 48));
            room = SECTOR - extent_bytes.size() + $urandom_range(1, 30);
            add_any(room < MIN_RECORD ? int'(MIN_RECORD) : room);
         end
      endcase
      repeat ($urandom_range(1, 2)) add_any($urandom_range(MIN_RECORD, 48));
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_byte(logic [7:0] b, logic fin);
      int gap;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_extent();
      foreach (extent_bytes[i]) send_byte(extent_bytes[i], i == extent_bytes.size() - 1);
      extent_bytes.delete();
   endtask

   // hold the input idle until every owed result is back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (book.entries_due.size() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      extent_bytes = '{8'd1};                              // too short on the final byte
      send_extent();
      extent_bytes = '{8'd33, 8'hFF, 8'h00};               // too short, rest discarded
      send_extent();
      extent_bytes = '{8'h00};                             // zero length as the final byte
      send_extent();
      extent_bytes = '{MIN_RECORD};                        // final byte is a length byte
      send_extent();
      extent_bytes = '{8'hFF, 8'h00, 8'hFF};               // overrun
      send_extent();
      extent_bytes = '{8'h00, 8'hAB, 8'hFF, 8'h00};        // padding ignored
      send_extent();
      // name overflow on the final byte wins over overrun
      add_record(MIN_RECORD, 2, 8'h41);
      extent_bytes.delete(extent_bytes.size() - 1);
      send_extent();
   endtask

   task automatic run_random();
      int unsigned turn;
      int unsigned rot;
      int unsigned longs;
      int unsigned pick;
      turn  = 0;
      longs = 0;
      rot   = $urandom_range(0, 2);
      while (longs < LONG_EXTENTS || bytes_sent < RANDOM_BYTES ||
             book.results_due < RESULTS_WANTED) begin
         if (longs < LONG_EXTENTS && turn % 6 == 3) begin
            build_long(long_shape_type'((rot + longs) % 3));
            longs++;
            send_extent();
            if (longs == 1) wait_drained();
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
               build_clean();
            else if (pick < 92)
               build_broken(broken_type'($urandom_range(0, 2)));
            else
               build_broken(BROKEN_NOISE);
            send_extent();
         end
         turn++;
      end
   endtask

   // ---------------------------------------------------------------- monitors

   always @(posedge clock) begin
      rsp_type seen;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) book.take_byte(req_ch.data_byte, req_ch.last_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.kind        = kind_type'(rsp_ch.kind);
            seen.extent_lba  = rsp_ch.extent_lba;
            seen.data_length = rsp_ch.data_length;
            seen.dir_entry   = rsp_ch.dir_entry;
            seen.id_len      = rsp_ch.id_len;
            seen.fault_code  = err_type'(rsp_ch.fault_code);
            seen.last        = rsp_ch.last;
            book.match_entry(seen);
         end
      end
   end

   // result side: random stall before each item, with calm stretches
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
         stall = recv_calm ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle = 0;
         else
            idle++;
      end
      $display("iso9660_dir_record_parser_unit test failed");
      $finish;
   end

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'h00;
      req_ch.last_byte <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_drained();
      run_random();
      wait_drained();
      repeat (16) @(posedge clock);
      if (book.mismatches == 0)
         $display("iso9660_dir_record_parser_unit test passed");
      else
         $display("iso9660_dir_record_parser_unit test failed");
      $finish;
   end

endmodule
